[sv/sle_pkg.sv]
// shared types, codes and constants of the serial line editor
`default_nettype none

package sle_pkg;

	localparam int LINE_BYTES_DEF = 64;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [7:0] ERASE_RESET = 8'd127;

	localparam int PADDR_W = 3;
	localparam logic REG_ERASE = 1'b0;

	typedef enum logic {
		ACT_RX    = 1'b0,
		ACT_FETCH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_CHAR  = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ECHO_LF,
		ST_ECHO_SP,
		ST_ECHO_BS2,
		ST_F_FIRST,
		ST_F_NEXT
	} state_t;

	typedef enum logic [2:0] {
		DSEL_CR,
		DSEL_LF,
		DSEL_BS,
		DSEL_SP,
		DSEL_RX,
		DSEL_HOLD,
		DSEL_ZERO
	} dsel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  capture;
		logic  emit;
		kind_t kind;
		dsel_t dsel;
		logic  last;
		logic  store_wr;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  clear_line;
		logic  set_ready;
		logic  hold_ld;
		logic  idx_inc;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_fetch;
		logic is_eol;
		logic is_erase;
		logic count_zero;
		logic count_full;
		logic line_ready;
		logic rdata_zero;
		logic idx_at_count;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[sv/sle_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/sle_dp.sv]
// datapath: input capture, line store, counters, erase register, result register
`default_nettype none

module sle_dp #(
	parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sle_pkg::in_item_t   item,
	input  wire sle_pkg::ctrl_cmd_t  cmd,
	output sle_pkg::dp_stat_t        stat,
	input  wire logic                cfg_wr,
	input  wire logic [7:0]          cfg_data,
	output logic      [7:0]          erase_code,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output sle_pkg::out_item_t       result
);

	localparam int DEPTH = LINE_BYTES - 1;
	localparam int CW    = $clog2(LINE_BYTES);

	sle_pkg::in_item_t  item_q;
	sle_pkg::out_item_t result_q;
	logic               result_valid_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic               ready_q;
	logic [7:0]         erase_q;
	logic [7:0]         hold_q;
	logic [7:0]         rdata;
	logic [7:0]         emit_data;
	logic [CW-1:0]      raddr;
	logic               out_free;

	// captured input item and fetch holding byte
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.hold_ld) begin
			hold_q <= rdata;
		end
	end

	// erase code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q <= sle_pkg::ERASE_RESET;
		end else if (cfg_wr) begin
			erase_q <= cfg_data;
		end
	end

	// character count, ready mark and fetch index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear_line) begin
				count_q <= '0;
				ready_q <= 1'b0;
			end else begin
				if (cmd.cnt_inc) begin
					count_q <= count_q + 1'b1;
				end else if (cmd.cnt_dec) begin
					count_q <= count_q - 1'b1;
				end
				if (cmd.set_ready) begin
					ready_q <= 1'b1;
				end
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// read one entry ahead when the index advances
	assign raddr = cmd.idx_inc ? idx_q + 1'b1 : idx_q;

	sle_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH),
		.AW    (CW)
	) u_store (
		.clk   (clk),
		.we    (cmd.store_wr),
		.waddr (count_q),
		.wdata (item_q.rx_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result byte selection
	always_comb begin
		case (cmd.dsel)
			sle_pkg::DSEL_CR:   emit_data = sle_pkg::CH_CR;
			sle_pkg::DSEL_LF:   emit_data = sle_pkg::CH_LF;
			sle_pkg::DSEL_BS:   emit_data = sle_pkg::CH_BS;
			sle_pkg::DSEL_SP:   emit_data = sle_pkg::CH_SP;
			sle_pkg::DSEL_RX:   emit_data = item_q.rx_byte;
			sle_pkg::DSEL_HOLD: emit_data = hold_q;
			default:            emit_data = sle_pkg::CH_NUL;
		endcase
	end

	// result register
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.kind <= cmd.kind;
			result_q.data <= emit_data;
			result_q.last <= cmd.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign erase_code   = erase_q;

	// status toward the controller
	always_comb begin
		stat.is_fetch     = (item_q.action == sle_pkg::ACT_FETCH);
		stat.is_eol       = (item_q.rx_byte == sle_pkg::CH_CR)
		                    || (item_q.rx_byte == sle_pkg::CH_LF);
		stat.is_erase     = (item_q.rx_byte == sle_pkg::CH_BS)
		                    || (item_q.rx_byte == erase_q);
		stat.count_zero   = (count_q == '0);
		stat.count_full   = (count_q == CW'(DEPTH));
		stat.line_ready   = ready_q;
		stat.rdata_zero   = (rdata == sle_pkg::CH_NUL);
		stat.idx_at_count = (idx_q == count_q);
		stat.out_free     = out_free;
	end

	// checks on datapath behavior
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result emitted while result register is occupied");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("character count beyond store depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_line |=> (count_q == '0) && !ready_q)
		else $error("line not cleared after fetch");

	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idx_inc |-> idx_q < count_q)
		else $error("fetch index runs past stored characters");

endmodule

`default_nettype wire

[sv/sle_ctrl.sv]
// controller: sequences echo, store and fetch steps for each item
`default_nettype none

module sle_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire sle_pkg::dp_stat_t  stat,
	output sle_pkg::ctrl_cmd_t      cmd
);

	sle_pkg::state_t state_q;
	sle_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		item_ready     = 1'b0;
		cmd            = '0;
		cmd.kind       = sle_pkg::KIND_ECHO;
		cmd.dsel       = sle_pkg::DSEL_ZERO;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				if (item_valid) begin
					state_d = sle_pkg::ST_DECODE;
				end
			end
			sle_pkg::ST_DECODE: begin
				if (stat.is_fetch) begin
					if (!stat.line_ready) begin
						cmd.kind = sle_pkg::KIND_NONE;
						cmd.dsel = sle_pkg::DSEL_ZERO;
						cmd.last = 1'b1;
						cmd.emit = stat.out_free;
						if (stat.out_free) begin
							state_d = sle_pkg::ST_IDLE;
						end
					end else if (stat.count_zero) begin
						cmd.kind       = sle_pkg::KIND_EMPTY;
						cmd.dsel       = sle_pkg::DSEL_ZERO;
						cmd.last       = 1'b1;
						cmd.emit       = stat.out_free;
						cmd.clear_line = stat.out_free;
						if (stat.out_free) begin
							state_d = sle_pkg::ST_IDLE;
						end
					end else begin
						state_d = sle_pkg::ST_F_FIRST;
					end
				end else if (stat.is_eol) begin
					cmd.dsel      = sle_pkg::DSEL_CR;
					cmd.emit      = stat.out_free;
					cmd.set_ready = stat.out_free;
					if (stat.out_free) begin
						state_d = sle_pkg::ST_ECHO_LF;
					end
				end else if (stat.is_erase) begin
					if (stat.count_zero) begin
						state_d = sle_pkg::ST_IDLE;
					end else begin
						cmd.dsel    = sle_pkg::DSEL_BS;
						cmd.emit    = stat.out_free;
						cmd.cnt_dec = stat.out_free;
						if (stat.out_free) begin
							state_d = sle_pkg::ST_ECHO_SP;
						end
					end
				end else if (stat.count_full) begin
					state_d = sle_pkg::ST_IDLE;
				end else begin
					cmd.dsel     = sle_pkg::DSEL_RX;
					cmd.last     = 1'b1;
					cmd.emit     = stat.out_free;
					cmd.store_wr = stat.out_free;
					cmd.cnt_inc  = stat.out_free;
					if (stat.out_free) begin
						state_d = sle_pkg::ST_IDLE;
					end
				end
			end
			sle_pkg::ST_ECHO_LF: begin
				cmd.dsel = sle_pkg::DSEL_LF;
				cmd.last = 1'b1;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = sle_pkg::ST_IDLE;
				end
			end
			sle_pkg::ST_ECHO_SP: begin
				cmd.dsel = sle_pkg::DSEL_SP;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = sle_pkg::ST_ECHO_BS2;
				end
			end
			sle_pkg::ST_ECHO_BS2: begin
				cmd.dsel = sle_pkg::DSEL_BS;
				cmd.last = 1'b1;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = sle_pkg::ST_IDLE;
				end
			end
			sle_pkg::ST_F_FIRST: begin
				// first stored byte is now on the read port
				if (stat.rdata_zero) begin
					cmd.kind       = sle_pkg::KIND_EMPTY;
					cmd.dsel       = sle_pkg::DSEL_ZERO;
					cmd.last       = 1'b1;
					cmd.emit       = stat.out_free;
					cmd.clear_line = stat.out_free;
					if (stat.out_free) begin
						state_d = sle_pkg::ST_IDLE;
					end
				end else begin
					cmd.hold_ld = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = sle_pkg::ST_F_NEXT;
				end
			end
			sle_pkg::ST_F_NEXT: begin
				// send held byte; the byte after it decides the last mark
				cmd.kind = sle_pkg::KIND_CHAR;
				cmd.dsel = sle_pkg::DSEL_HOLD;
				cmd.last = stat.idx_at_count || stat.rdata_zero;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					if (cmd.last) begin
						cmd.clear_line = 1'b1;
						state_d        = sle_pkg::ST_IDLE;
					end else begin
						cmd.hold_ld = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = sle_pkg::ST_IDLE;
			end
		endcase
	end

	// checks on sequencing
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == sle_pkg::ST_DECODE))
		else $error("accepted item did not reach decode");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sle_pkg::ST_IDLE) |-> !item_ready)
		else $error("input taken while an item is in work");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == sle_pkg::ST_IDLE))
		else $error("final result did not return controller to idle");

endmodule

`default_nettype wire

[sv/serial_line_editor_with_echo.sv]
// top level: serial line editor with echo, apb register port
// results: the first result is registered from the decode state after acceptance; a line
//   character of a fetch is registered from F_NEXT, after F_FIRST has read the store
// a new item is accepted only in idle, so not before the last item is through
// each emitting step waits while the result register stays occupied
// reset clears count, ready mark, erase code (127) and control; the line store is not cleared
`default_nettype none

module serial_line_editor_with_echo #(
	parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire sle_pkg::in_item_t            item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output sle_pkg::out_item_t                result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sle_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	sle_pkg::ctrl_cmd_t cmd;
	sle_pkg::dp_stat_t  stat;
	logic               cfg_wr;
	logic [7:0]         erase_code;

	// register access decode
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == sle_pkg::REG_ERASE);

	always_comb begin
		prdata = '0;
		if (paddr[2] == sle_pkg::REG_ERASE) begin
			prdata = {24'h0, erase_code};
		end
	end

	sle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sle_dp #(
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_wr),
		.cfg_data     (pwdata[7:0]),
		.erase_code   (erase_code),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
